/* rtl/core/nearest_free_extent_allocator_top_assert.svh */
// Assertion macros for the nearest free extent allocator
`ifndef NEAREST_FREE_EXTENT_ALLOCATOR_TOP_ASSERT_SVH
`define NEAREST_FREE_EXTENT_ALLOCATOR_TOP_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define NFEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define NFEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/nfea_pkg.sv */
// Package: types and constants of the nearest free extent allocator
package nfea_pkg;

  localparam int CLUSTER_BITS    = 28;
  localparam int COUNT_W         = 29;
  localparam int DEF_MAX_EXTENTS = 256;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 29'h1000_0000;
  localparam logic [31:0]        END_MARK_RST = 32'h0FFF_FFFF;
  localparam logic [31:0]        FREE_VALUE   = 32'h0000_0000;

  typedef enum logic [1:0] {
    MODE_SCAN    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NOP     = 2'd3
  } nfea_mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2
  } nfea_status_e;

  typedef struct packed {
    nfea_mode_e              mode;
    logic [CLUSTER_BITS-1:0] cluster;
    logic                    entry_free;
  } nfea_in_t;

  typedef struct packed {
    logic                    write_valid;
    logic [CLUSTER_BITS-1:0] write_cluster;
    logic [31:0]             write_value;
    logic [CLUSTER_BITS-1:0] chosen_cluster;
    nfea_status_e            status;
    logic [COUNT_W-1:0]      used_count;
    logic [COUNT_W-1:0]      free_count;
    logic                    last;
  } nfea_out_t;

  // one extent table entry
  typedef struct packed {
    logic [CLUSTER_BITS-1:0] start;
    logic [CLUSTER_BITS-1:0] len;
  } nfea_ext_t;

  function automatic logic [COUNT_W-1:0] inc_sat(input logic [COUNT_W-1:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] dec_sat(input logic [COUNT_W-1:0] v);
    return (v == '0) ? '0 : v - COUNT_W'(1);
  endfunction

endpackage

/* rtl/core/nfea_ext_ram.sv */
// Extent table memory: one write port, one registered read port
module nfea_ext_ram
  import nfea_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_EXTENTS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  nfea_ext_t         wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output nfea_ext_t         rdata_o
);

  nfea_ext_t mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/core/nearest_free_extent_allocator_top.sv */
// Top level of the nearest free extent allocator
//
// Input words (mode, cluster, entry_free) arrive on a valid/ready channel and
// are taken one at a time; the block accepts a word only when its sequencer
// is idle. Scan words open or grow the newest extent, allocate words take the
// nearest edge cluster of the nearest extent, release words merge a cluster
// back into the table. Result words leave on a valid/ready channel through a
// two-word output buffer: a successful allocate gives two words, every other
// word gives one.
// Allocate sweeps every extent and closes up the table when an extent is
// used up; release sweeps to the first extent at or above the cluster and
// may open or close a slot, all through the single read port of the table.
// end_mark is to be written through cfg_we_i / cfg_wdata_i only while the
// block is idle; the block itself does not enforce this.
// Reset clears the extent count, scan position and cluster counts; the table
// memory is not cleared, only entries below the count are ever read.
// While the receiver stalls, finished words wait in the output buffer and the
// next input word is still taken and worked on; it holds in its last step
// until the buffer has drained.
`include "nearest_free_extent_allocator_top_assert.svh"

module nearest_free_extent_allocator_top
  import nfea_pkg::*;
#(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  nfea_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output nfea_out_t out_data_o
);

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int CB    = CLUSTER_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_GROW, S_AL_SWEEP, S_AL_FIN,
    S_RL_SWEEP, S_RL_DEC, S_SHIFT, S_RL_INS, S_DONE
  } state_e;

  state_e            state_q, sh_next_q;
  nfea_mode_e        mode_q;
  logic [CB-1:0]     clu_q;
  logic              efree_q;
  logic [31:0]       end_mark_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CB-1:0]     scan_idx_q;
  logic              prev_used_q;
  logic [COUNT_W-1:0] used_q, free_q;
  // sweep
  logic [CNT_W-1:0]  rd_q, dv_idx_q;
  logic              dv_q;
  logic [CNT_W-1:0]  best_idx_q, p_q;
  logic [CB-1:0]     best_d_q;
  logic [CB-1:0]     bs_q, bl_q, rs_q, rl_q;
  logic              has_r_q;
  // shift engine
  logic [CNT_W-1:0]  sh_rd_q, sh_left_q, sh_wa_q;
  logic              sh_wv_q, sh_up_q;
  // pending result
  logic              r_wv_q, r_two_q;
  logic [CB-1:0]     r_wc_q, r_ch_q;
  logic [31:0]       r_val_q;
  nfea_status_e      r_st_q;
  // output buffer
  nfea_out_t         ob0_q, ob1_q;
  logic [1:0]        ob_n_q;

  // memory port
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  nfea_ext_t         mem_wd, mem_rd;

  nfea_ext_ram #(
    .DEPTH  (MAX_EXTENTS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .re_i    (mem_re),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  // distance of the requested cluster to the extent just read
  logic [CB+1:0] e_sum;
  logic          e_neg, near_lt_s, near_gt_e;
  logic [CB-1:0] ext_dist;
  assign e_sum     = {2'b00, mem_rd.start} + {2'b00, mem_rd.len} - (CB+2)'(1);
  assign e_neg     = e_sum[CB+1];
  assign near_lt_s = clu_q < mem_rd.start;
  assign near_gt_e = !e_neg && ({1'b0, clu_q} > e_sum[CB:0]);
  always_comb begin
    if (near_lt_s) ext_dist = mem_rd.start - clu_q;
    else if (near_gt_e) ext_dist = clu_q - e_sum[CB-1:0];
    else ext_dist = '0;
  end

  // allocation from the best extent
  logic          al_lt;
  logic [CB-1:0] al_cl, al_len;
  logic [CB+1:0] al_sum;
  assign al_lt  = clu_q < bs_q;
  assign al_sum = {2'b00, bs_q} + {2'b00, bl_q} - (CB+2)'(1);
  assign al_cl  = al_lt ? bs_q : al_sum[CB-1:0];
  assign al_len = bl_q - CB'(1);

  // release neighbour checks
  logic [CB:0]   end_l;
  logic          has_l, already, adj_l, adj_r;
  logic [CNT_W-1:0] p_m1;
  assign end_l   = {1'b0, bs_q} + {1'b0, bl_q};
  assign has_l   = p_q != '0;
  assign p_m1    = p_q - CNT_W'(1);
  assign already = (has_l && ({1'b0, clu_q} < end_l)) || (has_r_q && rs_q == clu_q);
  assign adj_l   = has_l && ({1'b0, clu_q} == end_l);
  assign adj_r   = has_r_q && (({1'b0, clu_q} + (CB+1)'(1)) == {1'b0, rs_q});

  logic table_full;
  assign table_full = cnt_q >= CNT_W'(MAX_EXTENTS);

  logic [CNT_W-1:0] cnt_m1;
  assign cnt_m1 = cnt_q - CNT_W'(1);

  // memory control per step
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    case (state_q)
      S_DISPATCH: begin
        if (mode_q == MODE_SCAN && efree_q) begin
          if (prev_used_q || cnt_q == '0) begin
            if (!table_full) begin
              mem_we = 1'b1;
              mem_wa = cnt_q[IDX_W-1:0];
              mem_wd = '{start: scan_idx_q, len: CB'(1)};
            end
          end else begin
            mem_re = 1'b1;
            mem_ra = cnt_m1[IDX_W-1:0];
          end
        end
      end
      S_GROW: begin
        mem_we = 1'b1;
        mem_wa = cnt_m1[IDX_W-1:0];
        mem_wd = '{start: mem_rd.start, len: mem_rd.len + CB'(1)};
      end
      S_AL_SWEEP, S_RL_SWEEP: begin
        mem_re = rd_q < cnt_q;
        mem_ra = rd_q[IDX_W-1:0];
      end
      S_AL_FIN: begin
        if (al_len != '0) begin
          mem_we = 1'b1;
          mem_wa = best_idx_q[IDX_W-1:0];
          mem_wd = '{start: al_lt ? bs_q + CB'(1) : bs_q, len: al_len};
        end
      end
      S_RL_DEC: begin
        if (!already) begin
          if (adj_l) begin
            mem_we = 1'b1;
            mem_wa = p_m1[IDX_W-1:0];
            mem_wd = '{start: bs_q,
                       len: adj_r ? bl_q + CB'(1) + rl_q : bl_q + CB'(1)};
          end else if (adj_r) begin
            mem_we = 1'b1;
            mem_wa = p_q[IDX_W-1:0];
            mem_wd = '{start: clu_q, len: rl_q + CB'(1)};
          end
        end
      end
      S_SHIFT: begin
        mem_we = sh_wv_q;
        mem_wa = sh_wa_q[IDX_W-1:0];
        mem_wd = mem_rd;
        mem_re = sh_left_q != '0;
        mem_ra = sh_rd_q[IDX_W-1:0];
      end
      S_RL_INS: begin
        mem_we = 1'b1;
        mem_wa = p_q[IDX_W-1:0];
        mem_wd = '{start: clu_q, len: CB'(1)};
      end
      default: ;
    endcase
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ob_n_q != 2'd0;
  assign out_data_o  = ob0_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_mark_q <= END_MARK_RST;
    end else if (cfg_we_i) begin
      end_mark_q <= cfg_wdata_i;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sh_next_q   <= S_DONE;
      mode_q      <= MODE_NOP;
      clu_q       <= '0;
      efree_q     <= 1'b0;
      cnt_q       <= '0;
      scan_idx_q  <= '0;
      prev_used_q <= 1'b1;
      used_q      <= '0;
      free_q      <= '0;
      rd_q        <= '0;
      dv_q        <= 1'b0;
      dv_idx_q    <= '0;
      best_idx_q  <= '0;
      best_d_q    <= '0;
      p_q         <= '0;
      bs_q        <= '0;
      bl_q        <= '0;
      rs_q        <= '0;
      rl_q        <= '0;
      has_r_q     <= 1'b0;
      sh_rd_q     <= '0;
      sh_left_q   <= '0;
      sh_wa_q     <= '0;
      sh_wv_q     <= 1'b0;
      sh_up_q     <= 1'b0;
      r_wv_q      <= 1'b0;
      r_two_q     <= 1'b0;
      r_wc_q      <= '0;
      r_ch_q      <= '0;
      r_val_q     <= '0;
      r_st_q      <= ST_OK;
      ob0_q       <= '0;
      ob1_q       <= '0;
      ob_n_q      <= 2'd0;
    end else begin
      // output buffer drain
      if (out_valid_o && out_ready_i) begin
        ob0_q  <= ob1_q;
        ob_n_q <= ob_n_q - 2'd1;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= in_data_i.mode;
            clu_q   <= in_data_i.cluster;
            efree_q <= in_data_i.entry_free;
            state_q <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          r_wv_q  <= 1'b0;
          r_wc_q  <= '0;
          r_val_q <= '0;
          r_ch_q  <= '0;
          r_st_q  <= ST_OK;
          r_two_q <= 1'b0;
          rd_q    <= '0;
          dv_q    <= 1'b0;
          state_q <= S_DONE;
          case (mode_q)
            MODE_SCAN: begin
              if (efree_q) begin
                if (prev_used_q || cnt_q == '0) begin
                  if (!table_full) begin
                    cnt_q       <= cnt_q + CNT_W'(1);
                    prev_used_q <= 1'b0;
                    free_q      <= inc_sat(free_q);
                  end else begin
                    r_st_q      <= ST_TABLE_FULL;
                    prev_used_q <= 1'b1;
                  end
                end else begin
                  free_q  <= inc_sat(free_q);
                  state_q <= S_GROW;
                end
              end else begin
                prev_used_q <= 1'b1;
                used_q      <= inc_sat(used_q);
              end
              scan_idx_q <= scan_idx_q + CB'(1);
              // wrap of the scan position closes any open extent
              if (scan_idx_q + CB'(1) == '0) begin
                prev_used_q <= 1'b1;
              end
            end
            MODE_ALLOC: begin
              if (cnt_q == '0) r_st_q <= ST_NO_SPACE;
              else state_q <= S_AL_SWEEP;
            end
            MODE_RELEASE: begin
              state_q <= S_RL_SWEEP;
            end
            default: ;
          endcase
        end

        S_GROW: begin
          state_q <= S_DONE;
        end

        // nearest extent search, first one wins ties
        S_AL_SWEEP: begin
          dv_q     <= mem_re;
          dv_idx_q <= rd_q;
          if (mem_re) rd_q <= rd_q + CNT_W'(1);
          if (dv_q) begin
            if (dv_idx_q == '0 || ext_dist < best_d_q) begin
              best_idx_q <= dv_idx_q;
              best_d_q   <= ext_dist;
              bs_q       <= mem_rd.start;
              bl_q       <= mem_rd.len;
            end
          end else if (!mem_re) begin
            state_q <= S_AL_FIN;
          end
        end

        S_AL_FIN: begin
          used_q  <= inc_sat(used_q);
          free_q  <= dec_sat(free_q);
          r_wv_q  <= 1'b1;
          r_wc_q  <= al_cl;
          r_val_q <= {{(32-CB){1'b0}}, al_cl};
          r_ch_q  <= al_cl;
          r_two_q <= 1'b1;
          if (al_len == '0) begin
            // extent used up: close the gap
            cnt_q     <= cnt_m1;
            sh_rd_q   <= best_idx_q + CNT_W'(1);
            sh_left_q <= cnt_m1 - best_idx_q;
            sh_up_q   <= 1'b0;
            sh_wv_q   <= 1'b0;
            sh_next_q <= S_DONE;
            state_q   <= S_SHIFT;
          end else begin
            state_q <= S_DONE;
          end
        end

        // find the first extent starting at or above the cluster
        S_RL_SWEEP: begin
          dv_q     <= mem_re;
          dv_idx_q <= rd_q;
          if (mem_re) rd_q <= rd_q + CNT_W'(1);
          if (dv_q && !(mem_rd.start < clu_q)) begin
            p_q     <= dv_idx_q;
            rs_q    <= mem_rd.start;
            rl_q    <= mem_rd.len;
            has_r_q <= 1'b1;
            state_q <= S_RL_DEC;
          end else if (dv_q) begin
            bs_q <= mem_rd.start;
            bl_q <= mem_rd.len;
          end else if (!mem_re) begin
            p_q     <= cnt_q;
            has_r_q <= 1'b0;
            state_q <= S_RL_DEC;
          end
        end

        S_RL_DEC: begin
          r_wv_q  <= 1'b1;
          r_wc_q  <= clu_q;
          r_val_q <= FREE_VALUE;
          state_q <= S_DONE;
          if (!already) begin
            if (adj_l || adj_r || !table_full) begin
              used_q <= dec_sat(used_q);
              free_q <= inc_sat(free_q);
            end
            if (adj_l && adj_r) begin
              // bridging release: drop the right extent
              cnt_q     <= cnt_m1;
              sh_rd_q   <= p_q + CNT_W'(1);
              sh_left_q <= cnt_m1 - p_q;
              sh_up_q   <= 1'b0;
              sh_wv_q   <= 1'b0;
              sh_next_q <= S_DONE;
              state_q   <= S_SHIFT;
            end else if (!adj_l && !adj_r) begin
              if (table_full) begin
                r_wv_q  <= 1'b0;
                r_wc_q  <= '0;
                r_st_q  <= ST_TABLE_FULL;
              end else begin
                // open a slot at p
                sh_rd_q   <= cnt_m1;
                sh_left_q <= cnt_q - p_q;
                sh_up_q   <= 1'b1;
                sh_wv_q   <= 1'b0;
                sh_next_q <= S_RL_INS;
                state_q   <= S_SHIFT;
              end
            end
          end
        end

        // move entries one place, read one ahead of the write
        S_SHIFT: begin
          if (mem_re) begin
            sh_rd_q   <= sh_up_q ? sh_rd_q - CNT_W'(1) : sh_rd_q + CNT_W'(1);
            sh_wa_q   <= sh_up_q ? sh_rd_q + CNT_W'(1) : sh_rd_q - CNT_W'(1);
            sh_wv_q   <= 1'b1;
            sh_left_q <= sh_left_q - CNT_W'(1);
          end else begin
            sh_wv_q <= 1'b0;
            if (!sh_wv_q) state_q <= sh_next_q;
          end
        end

        S_RL_INS: begin
          cnt_q   <= cnt_q + CNT_W'(1);
          state_q <= S_DONE;
        end

        S_DONE: begin
          if (ob_n_q == 2'd0) begin
            ob0_q <= '{write_valid: r_wv_q, write_cluster: r_wc_q,
                       write_value: r_two_q ? end_mark_q : r_val_q,
                       chosen_cluster: r_ch_q, status: r_st_q,
                       used_count: used_q, free_count: free_q,
                       last: !r_two_q};
            ob1_q <= '{write_valid: 1'b1, write_cluster: clu_q,
                       write_value: r_val_q, chosen_cluster: r_ch_q,
                       status: ST_OK, used_count: used_q,
                       free_count: free_q, last: 1'b1};
            ob_n_q  <= r_two_q ? 2'd2 : 2'd1;
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  `NFEA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_EXTENTS), "extent count beyond table size")
  `NFEA_ASSERT(a_no_rw_clash, !(mem_we && mem_re && mem_wa == mem_ra), "read and write of one entry")
  `NFEA_ASSERT(a_pair_order, ob_n_q != 2'd2 || (!ob0_q.last && ob1_q.last), "result pair out of order")
  `NFEA_ASSERT(a_idle_no_write, state_q != S_IDLE || !mem_we, "table written while idle")
  `NFEA_ASSERT_NEXT(a_done_loads, state_q == S_DONE && ob_n_q == 2'd0, out_valid_o, "result not presented")

endmodule
